>>> rtl/core/tscs_pkg.sv
// Shared constants and types of the threshold smooth color select unit.
package tscs_pkg;

    localparam int CHANNEL_BITS_DEFAULT = 16;
    localparam int CTRL_BITS            = 32;
    localparam int FALLOFF_BITS         = 31;
    localparam int WEIGHT_BITS          = 17;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;
    localparam int DIV_STAGES           = WEIGHT_BITS;

    typedef enum logic [0:0] {
        REG_THRESHOLD_LEVEL = 1'b0,
        REG_FALLOFF_WIDTH   = 1'b1
    } cfg_index_t;

endpackage

>>> rtl/core/threshold_smooth_color_select_unit.sv
// Top level of the threshold smooth color select unit: pipelined smootherstep color blend.
//
// Each input transaction on the s_ channel carries a signed Q16.16 control value and
// two RGBA colors (low and high). Each output transaction on the m_ channel carries
// one RGBA color: low, high, or a smootherstep blend between them when the control
// value falls inside the band of half width falloff_width around threshold_level.
// Both registers are written through cfg_wr_en, cfg_index and cfg_wdata, and must only
// be written while no transaction is in flight.
// The pipeline is 23 register stages deep; the first stage is loaded at the clock edge
// that accepts an input transaction. The stages are the band compare, the 17-stage
// restoring divider with one quotient bit per stage, three polynomial stages, one blend
// stage and the output register. Each stage holds a different transaction, so one is
// accepted every cycle while the skid buffer is empty. Reset clears both registers to
// zero (hard select at threshold zero) and empties the pipeline. When the receiver
// stalls, the output register holds its transaction and a one-entry skid buffer takes
// the next finished result; while the skid buffer is full s_tready is low and the whole
// pipeline holds, so nothing is lost or repeated.
module threshold_smooth_color_select_unit #(
    parameter int CHANNEL_BITS = tscs_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  tscs_pkg::cfg_index_t               cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: control_value, low_red, low_green, low_blue, low_alpha,
    // high_red, high_green, high_blue, high_alpha.
    input  logic [32+8*CHANNEL_BITS-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0 up: out_red, out_green, out_blue, out_alpha, zero padding.
    output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);
    import tscs_pkg::*;

    localparam int COLOR_W = 8 * CHANNEL_BITS;
    localparam int SIDE_W  = COLOR_W + 2;
    localparam int OUT_W   = ((4 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int PROD_W  = CHANNEL_BITS + WEIGHT_BITS;
    localparam int SUM_W   = PROD_W + 1;
    localparam int ST_P1   = DIV_STAGES + 1;
    localparam int ST_P2   = DIV_STAGES + 2;
    localparam int ST_P3   = DIV_STAGES + 3;
    localparam int ST_B1   = DIV_STAGES + 4;
    localparam int SEL_LO  = COLOR_W;
    localparam int SEL_HI  = COLOR_W + 1;

    // Configuration and values derived from it.
    logic signed [CTRL_BITS-1:0]    thr_reg, thr_next;
    logic [FALLOFF_BITS-1:0]        fall_reg, fall_next;
    logic signed [33:0]             lower_reg, upper_reg;
    logic [31:0]                    d_reg;
    logic                           zero_reg;

    // Pipeline.
    logic                           en;
    logic                           vld_reg [0:ST_B1];
    logic [SIDE_W-1:0]              side_reg [0:ST_P3];
    logic [32:0]                    rem_reg [0:DIV_STAGES];
    logic [WEIGHT_BITS-1:0]         quo_reg [0:DIV_STAGES];
    logic [33:0]                    rem_sh [1:DIV_STAGES];
    logic [33:0]                    rem_nx [1:DIV_STAGES];
    logic                           div_ge [1:DIV_STAGES];
    logic [WEIGHT_BITS-1:0]         t1_reg;
    logic [33:0]                    t2_reg;
    logic [34:0]                    cube_reg;
    logic [20:0]                    qf_reg;
    logic [WEIGHT_BITS-1:0]         s_reg;
    logic [PROD_W-1:0]              plo_reg [0:3];
    logic [PROD_W-1:0]              phi_reg [0:3];

    // Output register and skid buffer.
    logic                           out_vld_reg;
    logic [OUT_W-1:0]               out_data_reg;
    logic                           skid_vld_reg;
    logic [OUT_W-1:0]               skid_data_reg;

    // Front stage combinational signals.
    logic signed [33:0]             ctrl_x;
    logic signed [33:0]             diff;
    logic                           lt_low;
    logic                           gt_up;
    logic                           sel_low;
    logic                           sel_high;

    // Polynomial and blend combinational signals.
    logic [50:0]                    t3_w;
    logic [36:0]                    num_w;
    logic [55:0]                    sprod_w;
    logic [WEIGHT_BITS-1:0]         s_poly;
    logic [WEIGHT_BITS-1:0]         s_sel;
    logic [WEIGHT_BITS-1:0]         w_lo;
    logic [SUM_W-1:0]               sum_w [0:3];
    logic [OUT_W-1:0]               fin_data;

    always_comb begin
        thr_next  = thr_reg;
        fall_next = fall_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_THRESHOLD_LEVEL: thr_next  = $signed(cfg_wdata);
                REG_FALLOFF_WIDTH:   fall_next = cfg_wdata[FALLOFF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= '0;
            fall_reg  <= '0;
            lower_reg <= '0;
            upper_reg <= '0;
            d_reg     <= '0;
            zero_reg  <= 1'b1;
        end else begin
            thr_reg   <= thr_next;
            fall_reg  <= fall_next;
            lower_reg <= $signed({{2{thr_next[31]}}, thr_next}) - $signed({3'b000, fall_next});
            upper_reg <= $signed({{2{thr_next[31]}}, thr_next}) + $signed({3'b000, fall_next});
            d_reg     <= {fall_next, 1'b0};
            zero_reg  <= (fall_next == '0);
        end
    end

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    always_comb begin
        ctrl_x   = $signed({{2{s_tdata[31]}}, s_tdata[31:0]});
        lt_low   = ctrl_x < lower_reg;
        gt_up    = ctrl_x > upper_reg;
        sel_low  = lt_low;
        sel_high = zero_reg ? !lt_low : gt_up;
        diff     = ctrl_x - lower_reg;
    end

    always_comb begin
        for (int j = 1; j <= DIV_STAGES; j++) begin
            if (j == 1) begin
                rem_sh[j] = {1'b0, rem_reg[j-1]};
            end else begin
                rem_sh[j] = {rem_reg[j-1], 1'b0};
            end
            div_ge[j] = rem_sh[j] >= {2'b00, d_reg};
            rem_nx[j] = div_ge[j] ? (rem_sh[j] - {2'b00, d_reg}) : rem_sh[j];
        end
    end

    always_comb begin
        t3_w    = t2_reg * {34'd0, t1_reg};
        num_w   = ({3'b000, t2_reg} * 37'd6) + (37'd10 << 32)
                - ({4'b0000, t1_reg, 16'h0000} * 37'd15);
        sprod_w = {21'd0, cube_reg} * {35'd0, qf_reg};
        s_poly  = (sprod_w[55:32] > {7'd0, WEIGHT_ONE}) ? WEIGHT_ONE : sprod_w[48:32];
        if (side_reg[ST_P2][SEL_LO]) begin
            s_sel = '0;
        end else if (side_reg[ST_P2][SEL_HI]) begin
            s_sel = WEIGHT_ONE;
        end else begin
            s_sel = s_poly;
        end
        w_lo = WEIGHT_ONE - s_reg;
    end

    always_comb begin
        fin_data = '0;
        for (int k = 0; k < 4; k++) begin
            sum_w[k] = {1'b0, plo_reg[k]} + {1'b0, phi_reg[k]};
            fin_data[k*CHANNEL_BITS +: CHANNEL_BITS] = sum_w[k][CHANNEL_BITS+15:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= ST_B1; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= ST_B1; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= {sel_high, sel_low, s_tdata[32 +: COLOR_W]};
            for (int i = 1; i <= ST_P3; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            rem_reg[0] <= diff[32:0];
            quo_reg[0] <= '0;
            for (int j = 1; j <= DIV_STAGES; j++) begin
                rem_reg[j] <= rem_nx[j][32:0];
                quo_reg[j] <= {quo_reg[j-1][WEIGHT_BITS-2:0], div_ge[j]};
            end
            t1_reg   <= quo_reg[DIV_STAGES];
            t2_reg   <= {17'd0, quo_reg[DIV_STAGES]} * {17'd0, quo_reg[DIV_STAGES]};
            cube_reg <= t3_w[50:16];
            qf_reg   <= num_w[36:16];
            s_reg    <= s_sel;
            for (int k = 0; k < 4; k++) begin
                plo_reg[k] <= PROD_W'(side_reg[ST_P3][k*CHANNEL_BITS +: CHANNEL_BITS])
                              * PROD_W'(w_lo);
                phi_reg[k] <= PROD_W'(side_reg[ST_P3][(4+k)*CHANNEL_BITS +: CHANNEL_BITS])
                              * PROD_W'(s_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (vld_reg[ST_B1]) begin
            if (!out_vld_reg || m_tready) begin
                out_data_reg <= fin_data;
                out_vld_reg  <= 1'b1;
            end else begin
                skid_data_reg <= fin_data;
                skid_vld_reg  <= 1'b1;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_hard_select: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && zero_reg && !cfg_wr_en)
        |=> (side_reg[0][SEL_LO] != side_reg[0][SEL_HI]))
        else $error("Hard select did not pick exactly one color.");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_P3] |-> (s_reg <= WEIGHT_ONE))
        else $error("Blend weight exceeds one.");

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("Skid buffer holds a result while the output register is empty.");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("Skid buffer filled without an output stall.");
`endif

endmodule
